// ----- rtl/bitmap_id_allocator_top_assert.svh -----
// ----------------------------------------------------------------------------
// Bitmap ID allocator assertion macros
// Same-cycle and next-cycle implication checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ID_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_TOP_ASSERT_SVH

// cons must hold in the same cycle as ante
`define BIA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define BIA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bia_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap ID allocator package
// Field widths, default sizes and request codes shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bia_pkg;

  localparam int TYPE_W = 3;
  localparam int ID_W   = 8;

  localparam int ID_COUNT_DEF   = 256;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int WORD_COUNT_DEF = 8;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ALLOC   = 3'd0,
    REQ_RESERVE = 3'd1,
    REQ_FREE    = 3'd2,
    REQ_QUERY   = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_kind_t;

endpackage

// ----- rtl/bia_req_if.sv -----
// ----------------------------------------------------------------------------
// Bitmap ID allocator request channel
// Valid/ready channel carrying request kind and identifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bia_req_if;
  logic                      valid;
  logic                      ready;
  logic [bia_pkg::TYPE_W-1:0] req_type;
  logic [bia_pkg::ID_W-1:0]   id_number;

  modport source (output valid, req_type, id_number, input ready);
  modport sink   (input valid, req_type, id_number, output ready);
endinterface

// ----- rtl/bia_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Bitmap ID allocator response channel
// Valid/ready channel carrying status, granted identifier and query bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bia_rsp_if;
  logic                    valid;
  logic                    ready;
  logic                    status;
  logic [bia_pkg::ID_W-1:0] granted_id;
  logic                    is_used;

  modport source (output valid, status, granted_id, is_used, input ready);
  modport sink   (input valid, status, granted_id, is_used, output ready);
endinterface

// ----- rtl/bia_map_ram.sv -----
// ----------------------------------------------------------------------------
// Bitmap ID allocator map memory
// One write port and one registered read port holding the used bitmap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bia_map_ram #(
  parameter int WIDTH = bia_pkg::WORD_WIDTH_DEF,
  parameter int DEPTH = bia_pkg::WORD_COUNT_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bia_prienc.sv -----
// ----------------------------------------------------------------------------
// Bitmap ID allocator priority encoder
// Finds the lowest set bit of one bitmap word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bia_prienc #(
  parameter int W  = bia_pkg::WORD_WIDTH_DEF,
  parameter int IW = (W > 1) ? $clog2(W) : 1
) (
  input  logic [W-1:0]  vec,
  output logic          found,
  output logic [IW-1:0] idx
);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        found = 1'b1;
        idx   = IW'(i);
      end
    end
  end

endmodule

// ----- rtl/bitmap_id_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Bitmap ID allocator
// Next-fit identifier allocator over a word-organized used bitmap.
//
//   channel  dir  fields
//   req      in   req_type[2:0], id_number[7:0]
//   rsp      out  status, granted_id[7:0], is_used
//
// NW = words that hold identifiers (8 at defaults). The map memory is read
// one word per cycle and each word goes through the shared priority encoder.
// After reset a clearing pass over the map words runs before req.ready rises.
// A finished word waits in the output register; the next request may enter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bitmap_id_allocator_top_assert.svh"

module bitmap_id_allocator_top #(
  parameter int ID_COUNT   = bia_pkg::ID_COUNT_DEF,
  parameter int WORD_WIDTH = bia_pkg::WORD_WIDTH_DEF,
  parameter int WORD_COUNT = bia_pkg::WORD_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bia_req_if.sink    req,
  bia_rsp_if.source  rsp
);

  localparam int IDW    = $clog2(ID_COUNT);
  localparam int WAW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BW     = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;
  localparam int CW     = $clog2(ID_COUNT + WORD_COUNT * WORD_WIDTH);
  localparam int STORED = (ID_COUNT < WORD_COUNT * WORD_WIDTH) ?
                          ID_COUNT : WORD_COUNT * WORD_WIDTH;
  localparam int NW     = (STORED + WORD_WIDTH - 1) / WORD_WIDTH;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t                  state;
  bia_pkg::req_kind_t      kind;
  logic [bia_pkg::ID_W-1:0] id;
  logic [IDW-1:0]          ptr;
  logic                    clr_ack;

  logic                    issuing;
  logic [WAW-1:0]          rd_idx;
  logic [CW-1:0]           rd_base;
  logic                    chk_valid;
  logic [WAW-1:0]          chk_idx;
  logic [CW-1:0]           chk_base;

  logic                    rec_found;
  logic [WAW-1:0]          rec_idx;
  logic [CW-1:0]           rec_id;
  logic [WORD_WIDTH-1:0]   rec_data;

  logic                    res_status;
  logic [bia_pkg::ID_W-1:0] res_granted;
  logic                    res_used;

  logic                    out_valid;
  logic                    out_status;
  logic [bia_pkg::ID_W-1:0] out_granted;
  logic                    out_used;

  logic                    ram_we;
  logic [WAW-1:0]          ram_waddr;
  logic [WORD_WIDTH-1:0]   ram_wdata;
  logic                    ram_re;
  logic [WORD_WIDTH-1:0]   rdata;

  logic signed [CW:0]      sbase;
  logic signed [CW:0]      diff_p;
  logic signed [CW:0]      lim;
  logic signed [CW:0]      dt;
  logic [WORD_WIDTH-1:0]   free_vec;
  logic [WORD_WIDTH-1:0]   hi_vec;
  logic [WORD_WIDTH-1:0]   sel_vec;
  logic                    enc_found;
  logic [BW-1:0]           enc_idx;
  logic                    take_hi;
  logic                    take_any;
  logic                    last_word;
  logic                    tgt_hit;
  logic [BW-1:0]           tbit;
  logic [WORD_WIDTH-1:0]   enc_oh;
  logic [WORD_WIDTH-1:0]   tgt_oh;
  logic [CW-1:0]           cand_id;
  logic                    slot_free;

  bia_map_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (WORD_COUNT),
    .AW    (WAW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  bia_prienc #(
    .W  (WORD_WIDTH),
    .IW (BW)
  ) u_enc (
    .vec   (sel_vec),
    .found (enc_found),
    .idx   (enc_idx)
  );

  assign ram_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign ram_waddr = (state == S_CLEAR) ? rd_idx : rec_idx;
  assign ram_wdata = (state == S_CLEAR) ? '0 : rec_data;
  assign ram_re    = (state == S_SCAN) && issuing;

  // word-relative masks: bits at or past the pointer, bits below the stored limit
  always_comb begin
    logic signed [CW:0] jv;
    sbase  = $signed({1'b0, chk_base});
    diff_p = $signed({1'b0, CW'(ptr)}) - sbase;
    lim    = $signed((CW+1)'(STORED)) - sbase;
    dt     = $signed({1'b0, CW'(id)}) - sbase;
    for (int j = 0; j < WORD_WIDTH; j++) begin
      jv          = $signed((CW+1)'(j));
      free_vec[j] = !rdata[j] && (jv < lim);
      hi_vec[j]   = free_vec[j] && (jv >= diff_p);
    end
  end

  assign take_hi   = |hi_vec;
  assign sel_vec   = take_hi ? hi_vec : free_vec;
  assign take_any  = !take_hi && enc_found && !rec_found;
  assign last_word = (chk_idx == WAW'(NW - 1));
  assign cand_id   = chk_base + CW'(enc_idx);
  assign enc_oh    = WORD_WIDTH'(1) << enc_idx;
  assign tgt_hit   = (dt >= 0) && (dt < $signed((CW+1)'(WORD_WIDTH)));
  assign tbit      = dt[BW-1:0];
  assign tgt_oh    = WORD_WIDTH'(1) << tbit;
  assign slot_free = !out_valid || rsp.ready;

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.granted_id = out_granted;
  assign rsp.is_used    = out_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ptr       <= '0;
      clr_ack   <= 1'b0;
      rd_idx    <= '0;
      issuing   <= 1'b0;
      chk_valid <= 1'b0;
      rec_found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          rd_idx <= rd_idx + WAW'(1);
          if (rd_idx == WAW'(NW - 1)) begin
            state <= clr_ack ? S_RESP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            kind        <= bia_pkg::req_kind_t'(req.req_type);
            id          <= req.id_number;
            res_status  <= 1'b0;
            res_granted <= '0;
            res_used    <= 1'b0;
            rec_found   <= 1'b0;
            rd_idx      <= '0;
            rd_base     <= '0;
            chk_valid   <= 1'b0;
            issuing     <= 1'b1;
            clr_ack     <= 1'b0;
            unique case (bia_pkg::req_kind_t'(req.req_type))
              bia_pkg::REQ_ALLOC: begin
                state <= S_SCAN;
              end
              bia_pkg::REQ_RESERVE, bia_pkg::REQ_FREE, bia_pkg::REQ_QUERY: begin
                state <= (int'(req.id_number) >= STORED) ? S_RESP : S_SCAN;
              end
              bia_pkg::REQ_CLEAR: begin
                clr_ack <= 1'b1;
                state   <= S_CLEAR;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issuing) begin
            rd_idx  <= rd_idx + WAW'(1);
            rd_base <= rd_base + CW'(WORD_WIDTH);
            if (rd_idx == WAW'(NW - 1)) begin
              issuing <= 1'b0;
            end
          end
          chk_valid <= issuing;
          chk_idx   <= rd_idx;
          chk_base  <= rd_base;
          if (chk_valid) begin
            if (kind == bia_pkg::REQ_ALLOC) begin
              if (take_hi || take_any) begin
                rec_found <= 1'b1;
                rec_idx   <= chk_idx;
                rec_id    <= cand_id;
                rec_data  <= rdata | enc_oh;
              end
              if (take_hi || last_word) begin
                issuing   <= 1'b0;
                chk_valid <= 1'b0;
                if (take_hi || take_any || rec_found) begin
                  state <= S_WRITE;
                end else begin
                  res_status <= 1'b1;
                  ptr        <= (ptr == IDW'(ID_COUNT - 1)) ? '0 : ptr + IDW'(1);
                  state      <= S_RESP;
                end
              end
            end else if (tgt_hit) begin
              issuing   <= 1'b0;
              chk_valid <= 1'b0;
              rec_idx   <= chk_idx;
              if (kind == bia_pkg::REQ_QUERY) begin
                res_used <= rdata[tbit];
                state    <= S_RESP;
              end else begin
                rec_data <= (kind == bia_pkg::REQ_RESERVE) ? (rdata | tgt_oh) :
                            (rdata & ~tgt_oh);
                state    <= S_WRITE;
              end
            end
          end
        end
        S_WRITE: begin
          if (kind == bia_pkg::REQ_ALLOC) begin
            ptr         <= rec_id[IDW-1:0];
            res_granted <= bia_pkg::ID_W'(rec_id);
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            out_status  <= res_status;
            out_granted <= res_granted;
            out_used    <= res_used;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BIA_ASSERT_NEXT(a_one_at_a_time, clk, rst, req.valid && req.ready, !req.ready, "request taken while busy")
  `BIA_ASSERT_SAME(a_fail_clean, clk, rst, out_valid && out_status, (out_granted == '0) && !out_used, "failed allocate carries data")
  `BIA_ASSERT_SAME(a_ptr_range, clk, rst, 1'b1, ptr <= IDW'(ID_COUNT - 1), "search pointer out of range")
  `BIA_ASSERT_SAME(a_scan_bounds, clk, rst, chk_valid && (state == S_SCAN), chk_base < CW'(STORED), "scan past stored words")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap ID allocator testbench
// Drives allocate, reserve, free, query and clear words, including fill-to-full
// and free-then-reallocate runs. Every response word is checked against an
// in-bench model of the used bitmap and next-fit pointer. Sender and receiver
// idle at random across several phases. One phase holds the response side off
// for a long stretch.
// ----------------------------------------------------------------------------

module testbench;

  localparam int NUM_IDS      = bia_pkg::ID_COUNT_DEF;
  localparam int WORD_W       = bia_pkg::WORD_WIDTH_DEF;
  localparam int WORD_N       = bia_pkg::WORD_COUNT_DEF;
  localparam int TYPE_BITS    = bia_pkg::TYPE_W;
  localparam int ID_BITS      = bia_pkg::ID_W;
  localparam int DIRECTED_N   = 21;
  localparam int RANDOM_N     = 1750;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 600000;

  // request codes the block must treat as no-ops
  localparam logic [TYPE_BITS-1:0] REQ_BAD_FIRST = 3'd5;
  localparam logic [TYPE_BITS-1:0] REQ_BAD_LAST  = 3'd7;

  typedef struct packed {
    logic               status;
    logic [ID_BITS-1:0] granted_id;
    logic               is_used;
  } alloc_word_t;

  class alloc_scoreboard;
    bit [NUM_IDS-1:0] used_ids;
    int unsigned      scan_ptr;
    alloc_word_t      awaited[$];
    int               errors;

    function new();
      used_ids = '0;
      scan_ptr = 0;
      errors   = 0;
    endfunction

    function bit id_held(int unsigned idn);
      return idn < NUM_IDS && idn / WORD_W < WORD_N;
    endfunction

    function void note_request(logic [TYPE_BITS-1:0] kind, logic [ID_BITS-1:0] idn);
      alloc_word_t w;
      int unsigned c;
      bit          hit;
      w   = '0;
      hit = 1'b0;
      case (kind)
        bia_pkg::REQ_ALLOC: begin
          // next-fit: the pointer itself is examined first
          for (int unsigned n = 0; n < NUM_IDS && !hit; n++) begin
            c = (scan_ptr + n) % NUM_IDS;
            if (id_held(c) && !used_ids[c]) begin
              used_ids[c]  = 1'b1;
              scan_ptr     = c;
              w.granted_id = c[ID_BITS-1:0];
              hit          = 1'b1;
            end
          end
          if (!hit) begin
            scan_ptr = (scan_ptr + 1) % NUM_IDS;
            w.status = 1'b1;
          end
        end
        bia_pkg::REQ_RESERVE: if (id_held(idn)) used_ids[idn] = 1'b1;
        bia_pkg::REQ_FREE:    if (id_held(idn)) used_ids[idn] = 1'b0;
        bia_pkg::REQ_QUERY:   w.is_used = id_held(idn) && used_ids[idn];
        bia_pkg::REQ_CLEAR:   used_ids = '0;
        default: ;
      endcase
      awaited.push_back(w);
    endfunction

    function void check_result(logic st, logic [ID_BITS-1:0] gid, logic used);
      alloc_word_t w;
      if (awaited.size() == 0) begin
        $error("unexpected word: status=%0b granted_id=%0d is_used=%0b", st, gid, used);
        errors++;
        return;
      end
      w = awaited.pop_front();
      if (st !== w.status) begin
        $error("status: expected %0b, got %0b", w.status, st);
        errors++;
      end
      if (gid !== w.granted_id) begin
        $error("granted_id: expected %0d, got %0d", w.granted_id, gid);
        errors++;
      end
      if (used !== w.is_used) begin
        $error("is_used: expected %0b, got %0b", w.is_used, used);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   issued;
  int   req_idle_pct;
  int   rsp_stall_pct;
  bit   hold_go;
  bit   rsp_hold;

  alloc_scoreboard sb;

  bia_req_if req_ch ();
  bia_rsp_if rsp_ch ();

  bitmap_id_allocator_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_result(rsp_ch.status, rsp_ch.granted_id, rsp_ch.is_used);
  end

  // long receiver hold-off, counted here
  initial begin
    rsp_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    rsp_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold = 1'b0;
  end

  task automatic send_req(input logic [TYPE_BITS-1:0] kind, input logic [ID_BITS-1:0] idn);
    @(negedge clk);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.id_number <= idn;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(kind, idn);
    issued++;
  endtask

  task automatic drain_responses();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ID_BITS-1:0] pick_used_id();
    logic [ID_BITS-1:0] idn;
    idn = ID_BITS'($urandom);
    for (int k = 0; k < NUM_IDS; k++) begin
      if (sb.used_ids[idn]) return idn;
      idn++;
    end
    return idn;
  endfunction

  task automatic send_mixed();
    int                 r;
    logic [ID_BITS-1:0] idn;
    r   = $urandom_range(0, 99);
    idn = ID_BITS'($urandom);
    if (r < 45)
      send_req(bia_pkg::REQ_ALLOC, idn);
    else if (r < 55)
      send_req(bia_pkg::REQ_RESERVE, idn);
    else if (r < 75)
      send_req(bia_pkg::REQ_FREE, ($urandom_range(0, 3) != 0) ? pick_used_id() : idn);
    else if (r < 93)
      send_req(bia_pkg::REQ_QUERY, ($urandom_range(0, 1) != 0) ? pick_used_id() : idn);
    else
      send_req(TYPE_BITS'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST)), idn);
  endtask

  task automatic random_episode();
    int e;
    int len;
    e = $urandom_range(0, 19);
    if (e == 0) begin
      // allocate until full, overflow one to four times, then query one to four IDs
      len = NUM_IDS - $countones(sb.used_ids) + $urandom_range(1, 4);
      repeat (len) send_req(bia_pkg::REQ_ALLOC, ID_BITS'($urandom));
      repeat ($urandom_range(1, 4)) send_req(bia_pkg::REQ_QUERY, ID_BITS'($urandom));
    end else if (e == 1) begin
      send_req(bia_pkg::REQ_CLEAR, ID_BITS'($urandom));
    end else if (e == 2) begin
      drain_responses();
    end else if (e <= 6) begin
      // free some, then allocate again: next-fit skips the holes until wrap
      len = $urandom_range(1, 16);
      repeat (len) send_req(bia_pkg::REQ_FREE, pick_used_id());
      repeat ($urandom_range(1, len + 2)) send_req(bia_pkg::REQ_ALLOC, ID_BITS'($urandom));
    end else begin
      repeat ($urandom_range(4, 30)) send_mixed();
    end
  endtask

  initial begin
    sb               = new();
    cycles           = 0;
    issued           = 0;
    hold_go          = 1'b0;
    req_idle_pct     = 0;
    rsp_stall_pct    = 0;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = bia_pkg::REQ_ALLOC;
    req_ch.id_number = '0;
    rsp_ch.ready     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_req(bia_pkg::REQ_QUERY, 8'd0);
    send_req(bia_pkg::REQ_RESERVE, 8'd0);
    send_req(bia_pkg::REQ_RESERVE, 8'd255);
    send_req(bia_pkg::REQ_QUERY, 8'd0);
    send_req(bia_pkg::REQ_QUERY, 8'd255);
    send_req(bia_pkg::REQ_QUERY, 8'd128);
    send_req(bia_pkg::REQ_ALLOC, 8'd255);
    send_req(bia_pkg::REQ_ALLOC, 8'd0);
    send_req(bia_pkg::REQ_FREE, 8'd1);
    send_req(bia_pkg::REQ_ALLOC, 8'd170);
    send_req(bia_pkg::REQ_RESERVE, 8'd255);
    send_req(bia_pkg::REQ_FREE, 8'd200);
    send_req(REQ_BAD_FIRST, 8'd255);
    send_req(REQ_BAD_FIRST + 3'd1, 8'd0);
    send_req(REQ_BAD_LAST, 8'd170);
    send_req(bia_pkg::REQ_CLEAR, 8'd85);
    send_req(bia_pkg::REQ_QUERY, 8'd0);
    send_req(bia_pkg::REQ_ALLOC, 8'd85);
    send_req(bia_pkg::REQ_RESERVE, 8'd85);
    send_req(bia_pkg::REQ_FREE, 8'd255);
    send_req(bia_pkg::REQ_QUERY, 8'd255);
    drain_responses();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          req_idle_pct  = 0;
          rsp_stall_pct = 0;
          hold_go       = 1'b1;
        end
        1: begin
          req_idle_pct  = 74;
          rsp_stall_pct = 0;
        end
        2: begin
          req_idle_pct  = 0;
          rsp_stall_pct = 74;
        end
        default: begin
          req_idle_pct  = 21;
          rsp_stall_pct = 21;
        end
      endcase
      while (issued < DIRECTED_N + (ph + 1) * RANDOM_N / 4) random_episode();
      drain_responses();
    end

    repeat (32) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
